[rtl/wios_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wios_pkg: shared types and constants
// constants and the cordic arctangent table for the odometry step
// ----------------------------------------------------------------------------
package wios_pkg;
    localparam int unsigned PiQ13      = 25736;
    localparam int unsigned HalfPiQ13  = 12868;
    localparam int unsigned TwoPiQ13   = 51472;
    localparam int unsigned CordicN    = 16;
    localparam logic [31:0] CordicGain = 32'd652032874;
    localparam logic [15:0] StaleReset = 16'd1000;
    localparam logic [19:0] UsPerS     = 20'd1000000;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_CORDIC,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } state_t;

    function automatic logic [17:0] atan_q16(input logic [3:0] i);
        logic [17:0] r;
        unique case (i)
            4'd0:  r = 18'd51472;
            4'd1:  r = 18'd30386;
            4'd2:  r = 18'd16055;
            4'd3:  r = 18'd8150;
            4'd4:  r = 18'd4091;
            4'd5:  r = 18'd2047;
            4'd6:  r = 18'd1024;
            4'd7:  r = 18'd512;
            4'd8:  r = 18'd256;
            4'd9:  r = 18'd128;
            4'd10: r = 18'd64;
            4'd11: r = 18'd32;
            4'd12: r = 18'd16;
            4'd13: r = 18'd8;
            4'd14: r = 18'd4;
            default: r = 18'd2;
        endcase
        return r;
    endfunction
endpackage
`default_nettype wire

[rtl/wheel_imu_odometry_step.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wheel_imu_odometry_step: differential drive odometry with imu heading
// integrates wheel travel along the imu heading, reports pose and speed
// ----------------------------------------------------------------------------
// One item is taken at a time. When the averaged wheel delta and the elapsed
// time are both zero the result goes straight out; when only the elapsed time
// is nonzero only the divider runs; when the average is nonzero the cordic and
// the multiplier run, then the divider if the elapsed time is nonzero: a
// 16-step cordic, a 34-step bit-serial multiplier used twice (x then y) and a
// 54-step restoring divider for speed run one after the other. The result
// waits in an output register; the next item is taken once the finished
// result has moved into that register, so a stalled receiver holds the block
// in its last step.
module wheel_imu_odometry_step (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    // stale limit register, milliseconds
    input  wire logic         cfg_wr_en,
    input  wire logic [15:0]  cfg_wr_data,
    // input item
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // tdata: left_distance[31:0], right_distance[63:32], imu_hdg[79:64],
    //        imu_yaw_rate[95:80], imu_time_ms[127:96], elapsed_us[151:128]
    input  wire logic [151:0] s_tdata,
    // result item
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // tdata: pos_x[31:0], pos_y[63:32], heading[79:64], speed[111:80],
    //        yaw_rate[127:112], imu_stale[128], zero pad [135:129]
    output logic [135:0]      m_tdata
);
    wios_pkg::state_t state_reg, state_next;

    logic [15:0] stale_limit_reg;
    logic signed [31:0] x_reg, y_reg, prev_l_reg, prev_r_reg;
    logic signed [15:0] head_reg;
    logic [31:0] prev_t_reg;

    // latched item
    logic signed [33:0] avg_reg;
    logic signed [15:0] imu_h_reg, yaw_reg;
    logic [23:0] dt_reg;
    logic        stale_reg;
    logic        neg_trig_reg;
    logic        mul_y_reg;
    logic signed [31:0] speed_reg;
    logic        out_valid_reg;
    logic [135:0] out_reg;

    logic signed [32:0] dl, dr;
    logic signed [33:0] dsum;
    logic [32:0] t_lim;

    assign dl    = 33'(signed'(s_tdata[31:0])) - 33'(prev_l_reg);
    assign dr    = 33'(signed'(s_tdata[63:32])) - 33'(prev_r_reg);
    assign dsum  = 34'(dl) + 34'(dr);
    assign t_lim = {1'b0, prev_t_reg} + {17'd0, stale_limit_reg};

    // angle reduction: phi = 2h - H into [-pi, pi), then fold to +-pi/2
    logic signed [19:0] phi, r1, r2;
    logic signed [19:0] pi_s, tpi_s, hpi_s;
    assign pi_s  = 20'(wios_pkg::PiQ13);
    assign tpi_s = 20'(wios_pkg::TwoPiQ13);
    assign hpi_s = 20'(wios_pkg::HalfPiQ13);
    assign phi = 20'(head_reg) * 20'sd2 - 20'(imu_h_reg);
    // phi within +-3*2^15, so up to two corrections
    always_comb begin
        r1 = phi;
        if (r1 >= pi_s) r1 = r1 - tpi_s;
        else if (r1 < -pi_s) r1 = r1 + tpi_s;
        if (r1 >= pi_s) r1 = r1 - tpi_s;
        else if (r1 < -pi_s) r1 = r1 + tpi_s;
        r2 = r1;
        if (r1 > hpi_s) r2 = r1 - pi_s;
        else if (r1 < -hpi_s) r2 = r1 + pi_s;
    end

    // folded angle in q3.16, taken by the cordic at its start
    logic signed [19:0] ang_v;
    assign ang_v = r2 * 20'sd8;

    // shared units
    logic cor_start, cor_done;
    logic signed [33:0] cos_v, sin_v;
    wios_cordic u_cordic (
        .aclk(aclk), .aresetn(aresetn), .start(cor_start), .angle(ang_v),
        .done(cor_done), .cos_out(cos_v), .sin_out(sin_v)
    );

    // cos for the first product (started from the cordic step), sin for the second
    logic mul_start, mul_done;
    logic signed [33:0] trig_sel;
    logic signed [67:0] prod;
    assign trig_sel = (state_reg == wios_pkg::ST_MUL)
                    ? (neg_trig_reg ? 34'(-sin_v) : sin_v)
                    : (neg_trig_reg ? 34'(-cos_v) : cos_v);
    wios_serial_mul u_mul (
        .aclk(aclk), .aresetn(aresetn), .start(mul_start), .mcand(avg_reg),
        .mplier(trig_sel), .done(mul_done), .product(prod)
    );

    logic div_start, div_done;
    logic [53:0] div_num, quot;
    logic [33:0] avg_abs;
    assign avg_abs = avg_reg[33] ? 34'(-avg_reg) : 34'(avg_reg);
    assign div_num = 54'(avg_abs) * 54'(wios_pkg::UsPerS);
    wios_serial_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(div_start), .dividend(div_num),
        .divisor(dt_reg), .done(div_done), .quotient(quot)
    );

    // rounded product and saturating add
    logic signed [37:0] rnd;
    logic signed [37:0] acc_sum;
    logic signed [31:0] acc_sat;
    assign rnd = 38'((prod + 68'sd536870912) >>> 30);
    assign acc_sum = 38'(mul_y_reg ? y_reg : x_reg) + rnd;
    always_comb begin
        if (acc_sum > 38'sd2147483647) acc_sat = 32'h7fffffff;
        else if (acc_sum < -38'sd2147483648) acc_sat = 32'h80000000;
        else acc_sat = acc_sum[31:0];
    end

    // signed saturated speed
    logic signed [31:0] spd_sat;
    always_comb begin
        if (!avg_reg[33]) begin
            spd_sat = (quot > 54'd2147483647) ? 32'h7fffffff : quot[31:0];
        end else begin
            spd_sat = (quot > 54'd2147483648) ? 32'h80000000 : 32'(-quot);
        end
    end

    logic take, out_free;
    assign out_free = !out_valid_reg || m_tready;
    assign s_tready = (state_reg == wios_pkg::ST_IDLE);
    assign take     = s_tvalid && s_tready;

    // control
    always_comb begin
        state_next = state_reg;
        cor_start  = 1'b0;
        mul_start  = 1'b0;
        div_start  = 1'b0;
        unique case (state_reg)
            wios_pkg::ST_IDLE: if (take) state_next = wios_pkg::ST_PREP;
            wios_pkg::ST_PREP: begin
                if (avg_reg != 34'sd0) begin
                    cor_start  = 1'b1;
                    state_next = wios_pkg::ST_CORDIC;
                end else if (dt_reg != 24'd0) begin
                    div_start  = 1'b1;
                    state_next = wios_pkg::ST_DIV;
                end else begin
                    state_next = wios_pkg::ST_DONE;
                end
            end
            wios_pkg::ST_CORDIC: if (cor_done) begin
                mul_start  = 1'b1;
                state_next = wios_pkg::ST_MUL;
            end
            wios_pkg::ST_MUL: if (mul_done) begin
                if (!mul_y_reg) mul_start = 1'b1;
                else if (dt_reg != 24'd0) begin
                    div_start  = 1'b1;
                    state_next = wios_pkg::ST_DIV;
                end else state_next = wios_pkg::ST_DONE;
            end
            wios_pkg::ST_DIV: if (div_done) state_next = wios_pkg::ST_DONE;
            wios_pkg::ST_DONE: if (out_free) state_next = wios_pkg::ST_IDLE;
            default: state_next = wios_pkg::ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= wios_pkg::ST_IDLE;
            stale_limit_reg <= wios_pkg::StaleReset;
            x_reg           <= '0;
            y_reg           <= '0;
            head_reg        <= '0;
            prev_l_reg      <= '0;
            prev_r_reg      <= '0;
            prev_t_reg      <= '0;
            out_valid_reg   <= 1'b0;
            mul_y_reg       <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) stale_limit_reg <= cfg_wr_data;
            if (take) begin
                // halve the wheel delta sum, rounding down
                avg_reg    <= dsum >>> 1;
                imu_h_reg  <= signed'(s_tdata[79:64]);
                yaw_reg    <= signed'(s_tdata[95:80]);
                dt_reg     <= s_tdata[151:128];
                stale_reg  <= (prev_t_reg != 32'd0) &&
                              ({1'b0, s_tdata[127:96]} > t_lim);
                prev_t_reg <= s_tdata[127:96];
                prev_l_reg <= signed'(s_tdata[31:0]);
                prev_r_reg <= signed'(s_tdata[63:32]);
                speed_reg  <= '0;
                mul_y_reg  <= 1'b0;
            end
            if (state_reg == wios_pkg::ST_PREP) begin
                neg_trig_reg <= (r1 > hpi_s) || (r1 < -hpi_s);
            end
            if (state_reg == wios_pkg::ST_MUL && mul_done) begin
                if (mul_y_reg) y_reg <= acc_sat;
                else begin
                    x_reg     <= acc_sat;
                    mul_y_reg <= 1'b1;
                end
            end
            if (state_reg == wios_pkg::ST_DIV && div_done) speed_reg <= spd_sat;
            if (state_reg == wios_pkg::ST_DONE && out_free) begin
                head_reg      <= imu_h_reg;
                out_valid_reg <= 1'b1;
                out_reg       <= {7'd0, stale_reg, yaw_reg, speed_reg, imu_h_reg,
                                  y_reg, x_reg};
            end else if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_reg;
endmodule
`default_nettype wire

[rtl/wios_cordic.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wios_cordic: rotation-mode cordic, one micro-rotation per cycle
// takes a reduced angle in q3.16 and returns cos and sin in q3.30
// ----------------------------------------------------------------------------
module wios_cordic (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [19:0] angle,
    output logic                    done,
    output logic signed [33:0]      cos_out,
    output logic signed [33:0]      sin_out
);
    logic signed [33:0] x_reg, y_reg;
    logic signed [20:0] z_reg;
    logic [3:0]  i_reg;
    logic        busy_reg;
    logic        done_reg;
    logic signed [33:0] xs, ys;
    logic signed [20:0] a;

    assign xs = x_reg >>> i_reg;
    assign ys = y_reg >>> i_reg;
    assign a  = signed'({3'b000, wios_pkg::atan_q16(i_reg)});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            i_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                i_reg    <= '0;
                x_reg    <= signed'({2'b00, wios_pkg::CordicGain});
                y_reg    <= '0;
                z_reg    <= {angle[19], angle};
            end else if (busy_reg) begin
                if (!z_reg[20]) begin
                    x_reg <= x_reg - ys;
                    y_reg <= y_reg + xs;
                    z_reg <= z_reg - a;
                end else begin
                    x_reg <= x_reg + ys;
                    y_reg <= y_reg - xs;
                    z_reg <= z_reg + a;
                end
                i_reg <= i_reg + 4'd1;
                if (i_reg == 4'(wios_pkg::CordicN - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign cos_out = x_reg;
    assign sin_out = y_reg;
endmodule
`default_nettype wire

[rtl/wios_serial_mul.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wios_serial_mul: bit-serial signed multiplier
// shift-and-add over the multiplier bits, one bit per cycle
// ----------------------------------------------------------------------------
module wios_serial_mul (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               start,
    input  wire logic signed [33:0] mcand,
    input  wire logic signed [33:0] mplier,
    output logic                    done,
    output logic signed [67:0]      product
);
    logic [33:0] mag_b_reg;
    logic [67:0] acc_reg;
    logic [67:0] a_reg;
    logic        neg_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [33:0] abs_a, abs_b;

    assign abs_a = mcand[33] ? 34'(-mcand) : 34'(mcand);
    assign abs_b = mplier[33] ? 34'(-mplier) : 34'(mplier);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg  <= 1'b1;
                cnt_reg   <= '0;
                acc_reg   <= '0;
                a_reg     <= {34'd0, abs_a};
                mag_b_reg <= abs_b;
                neg_reg   <= mcand[33] ^ mplier[33];
            end else if (busy_reg) begin
                if (mag_b_reg[0]) acc_reg <= acc_reg + a_reg;
                a_reg     <= a_reg << 1;
                mag_b_reg <= mag_b_reg >> 1;
                cnt_reg   <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd33) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done    = done_reg;
    assign product = neg_reg ? signed'(68'(-acc_reg)) : signed'(acc_reg);
endmodule
`default_nettype wire

[rtl/wios_serial_div.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wios_serial_div: restoring divider, one quotient bit per cycle
// unsigned 54-bit dividend by 24-bit divisor, quotient truncated
// ----------------------------------------------------------------------------
module wios_serial_div (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        start,
    input  wire logic [53:0] dividend,
    input  wire logic [23:0] divisor,
    output logic             done,
    output logic [53:0]      quotient
);
    logic [53:0] q_reg;
    logic [24:0] r_reg;
    logic [23:0] d_reg;
    logic [5:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [24:0] r_sh;

    assign r_sh = {r_reg[23:0], q_reg[53]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
                q_reg    <= dividend;
                r_reg    <= '0;
                d_reg    <= divisor;
            end else if (busy_reg) begin
                if (r_sh >= {1'b0, d_reg}) begin
                    r_reg <= r_sh - {1'b0, d_reg};
                    q_reg <= {q_reg[52:0], 1'b1};
                end else begin
                    r_reg <= r_sh;
                    q_reg <= {q_reg[52:0], 1'b0};
                end
                cnt_reg <= cnt_reg + 6'd1;
                if (cnt_reg == 6'd53) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;
endmodule
`default_nettype wire
